### hw/rtl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// No dependencies; every other file of the block but bpa_queue refers to it by scoped names.
package bpa_pkg;

   localparam int NUM_PAGES     = 4096;
   localparam int BITS_PER_WORD = 64;
   localparam int WORDS         = NUM_PAGES / BITS_PER_WORD;
   localparam int WORD_AW       = $clog2(WORDS);
   localparam int BIT_AW        = $clog2(BITS_PER_WORD);
   localparam int PAGE_W        = 13;
   localparam int RUN_W         = 16;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [PAGE_W-1:0] MANAGED_RESET = PAGE_W'(NUM_PAGES);

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_FREE    = 2'd1,
      REQ_RESERVE = 2'd2,
      REQ_RELEASE = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_OOM     = 3'd1,
      ST_NO_RUN  = 3'd2,
      ST_INVALID = 3'd3,
      ST_DOUBLE  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PASS_CHECK,
      PASS_SET,
      PASS_CLEAR
   } pass_mode_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_START,
      BK_SCAN_RD,
      BK_SCAN_EV,
      BK_PASS_RD,
      BK_PASS_EV,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  order;
      logic [11:0] start_page;
      logic [12:0] page_count;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [11:0] alloc_page;
      logic [12:0] free_total;
   } rsp_item_type;

   // Classified request handed from the front end to the sequencer.
   typedef struct packed {
      req_kind_type      kind;
      logic [3:0]        order;
      logic [RUN_W-1:0]  run;
      logic [PAGE_W-1:0] lo;
      logic [PAGE_W-1:0] hi;
      logic              invalid;
   } cmd_type;

endpackage

### hw/rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: control register, front end,
// request queue, sequencer and result queue. Depends on bpa_pkg and the bpa_* modules.
// Usage:
//  - Requests enter as a queue: drive req_data and raise push; a request is
//    taken at a clock edge with push high and full low. Two requests may
//    wait in the command queue while the sequencer works.
//  - Results leave as a queue: while empty is low rsp_data holds the oldest
//    result; raise pop to take it. Results come back in request order, one
//    per request, and the result queue holds two.
//  - csr_we/csr_wdata write the managed page count; write only while idle.
//  - Each bitmap word touched is read, then evaluated or read-modify-written,
//    each in a state of its own, between a dispatch step and completion. A
//    request that fails up front answers without touching the bitmap; a
//    granted allocate scans up to 64 words and then marks its run.
//    A free checks, then clears, its words; a range walks them once.
//  - The single-port bitmap memory sets the rate: one item at a time.
//  - Reset marks every page used, zeroes the free count and sets the
//    managed size to 4096 pages; the bitmap needs no clearing pass.
//  - When the receiver stalls, the sequencer holds its result until the
//    result queue has room, and the command queue then fills and raises full.
module bitmap_page_allocator #(
   parameter int QueueDepth = bpa_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  bpa_pkg::req_item_type        req_data,
   output logic                         empty,
   input  logic                         pop,
   output bpa_pkg::rsp_item_type        rsp_data,
   input  logic                         csr_we,
   input  logic [bpa_pkg::PAGE_W-1:0]   csr_wdata
);

   logic [bpa_pkg::PAGE_W-1:0] managed_ff, managed_in;
   logic [bpa_pkg::PAGE_W-1:0] limit;

   bpa_pkg::cmd_type      front_cmd;
   bpa_pkg::cmd_type      cmd_data;
   logic                  cmd_empty;
   logic                  cmd_pop;
   bpa_pkg::rsp_item_type back_rsp;
   logic                  rsp_full;
   logic                  rsp_push;

   // hold the managed size; clamp it to the bitmap size
   always_comb begin
      managed_in = csr_we ? csr_wdata : managed_ff;
      limit      = (managed_ff > bpa_pkg::MANAGED_RESET) ? bpa_pkg::MANAGED_RESET
                                                         : managed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         managed_ff <= bpa_pkg::MANAGED_RESET;
      end else begin
         managed_ff <= managed_in;
      end
   end

   // classify the request into a clipped page range
   bpa_front u_front (
      .req   (req_data),
      .limit (limit),
      .cmd   (front_cmd)
   );

   // decouple acceptance from the sequencer
   bpa_queue #(
      .item_type (bpa_pkg::cmd_type),
      .Depth     (QueueDepth)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (front_cmd),
      .full    (full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_data),
      .empty   (cmd_empty)
   );

   // scan, check and mark the bitmap
   bpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_item  (back_rsp),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push)
   );

   // buffer results so a stalled receiver does not block the next request
   bpa_queue #(
      .item_type (bpa_pkg::rsp_item_type),
      .Depth     (QueueDepth)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

endmodule

### hw/rtl/bpa_queue.sv
// Small first-in first-out queue of packed items.
// Depends on nothing but its parameters.
module bpa_queue #(
   parameter type item_type = logic,
   parameter int  Depth     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output item_type rd_data,
   output logic     empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   item_type            slot_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_wr, do_rd;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### hw/rtl/bpa_front.sv
// Request classifier: turns a raw request into a page range and run length.
// Depends on bpa_pkg.
module bpa_front (
   input  bpa_pkg::req_item_type         req,
   input  logic [bpa_pkg::PAGE_W-1:0]    limit,
   output bpa_pkg::cmd_type              cmd
);

   logic [bpa_pkg::RUN_W-1:0]  run;
   logic [bpa_pkg::RUN_W:0]    len;
   logic [bpa_pkg::RUN_W:0]    range_end;
   logic [bpa_pkg::PAGE_W-1:0] start;
   bpa_pkg::req_kind_type      kind;

   always_comb begin
      kind  = bpa_pkg::req_kind_type'(req.req_type);
      run   = bpa_pkg::RUN_W'(1) << req.order;
      start = bpa_pkg::PAGE_W'(req.start_page);
      len   = (kind == bpa_pkg::REQ_FREE) ? (bpa_pkg::RUN_W + 1)'(run)
                                          : (bpa_pkg::RUN_W + 1)'(req.page_count);
      range_end = (bpa_pkg::RUN_W + 1)'(start) + len;

      cmd.kind    = kind;
      cmd.order   = req.order;
      cmd.run     = run;
      cmd.invalid = (kind == bpa_pkg::REQ_FREE) && (start >= limit);
      if (kind == bpa_pkg::REQ_ALLOC) begin
         cmd.lo = '0;
         cmd.hi = limit;
      end else begin
         // clip the run to the managed pages
         cmd.lo = start;
         cmd.hi = (range_end < (bpa_pkg::RUN_W + 1)'(limit))
                  ? bpa_pkg::PAGE_W'(range_end) : limit;
      end
   end

endmodule

### hw/rtl/bpa_back.sv
// Sequencer that owns the usage bitmap: first-fit scan, check, mark and clear passes.
// Depends on bpa_pkg.
module bpa_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bpa_pkg::PAGE_W-1:0]    limit,
   input  bpa_pkg::cmd_type              cmd_data,
   input  logic                          cmd_empty,
   output logic                          cmd_pop,
   output bpa_pkg::rsp_item_type         rsp_item,
   input  logic                          rsp_full,
   output logic                          rsp_push
);

   localparam int W  = bpa_pkg::BITS_PER_WORD;
   localparam int AW = bpa_pkg::WORD_AW;
   localparam int BW = bpa_pkg::BIT_AW;
   localparam int PW = bpa_pkg::PAGE_W;

   function automatic logic [W-1:0] below_mask(input logic [BW:0] n);
      logic [W-1:0] m;
      for (int b = 0; b < W; b++) begin
         m[b] = (BW + 1)'(b) < n;
      end
      return m;
   endfunction

   function automatic logic [BW:0] pop_count(input logic [W-1:0] v);
      logic [BW:0] s;
      s = '0;
      for (int b = 0; b < W; b++) begin
         s = s + (BW + 1)'(v[b]);
      end
      return s;
   endfunction

   function automatic logic [BW:0] low_ones(input logic [W-1:0] v);
      logic [BW:0] n;
      n = (BW + 1)'(W);
      for (int b = W - 1; b >= 0; b--) begin
         if (!v[b]) n = (BW + 1)'(b);
      end
      return n;
   endfunction

   function automatic logic [BW:0] high_ones(input logic [W-1:0] v);
      logic [BW:0] n;
      n = (BW + 1)'(W);
      for (int b = 0; b < W; b++) begin
         if (!v[b]) n = (BW + 1)'(W - 1 - b);
      end
      return n;
   endfunction

   // bitmap storage: a set bit marks a used page; unwritten words read as used
   logic [W-1:0]     mem_ff [bpa_pkg::WORDS];
   logic [bpa_pkg::WORDS-1:0] valid_ff;
   logic [W-1:0]     rd_data_ff;
   logic             rd_valid_ff;

   bpa_pkg::back_state_type state_ff, state_in;
   bpa_pkg::cmd_type        cmd_ff, cmd_in;
   bpa_pkg::pass_mode_type  mode_ff, mode_in;
   bpa_pkg::status_type     status_ff, status_in;
   logic [AW-1:0]    word_ff, word_in;
   logic [PW-1:0]    streak_ff, streak_in;
   logic [W-1:0]     prevf_ff, prevf_in;
   logic [PW-1:0]    lo_ff, lo_in;
   logic [PW-1:0]    hi_ff, hi_in;
   logic [11:0]      grant_ff, grant_in;
   logic [PW-1:0]    fc_ff, fc_in;

   logic             mem_rd, mem_we;
   logic [W-1:0]     mem_wdata;

   logic [W-1:0]     rd_word;
   logic [PW-1:0]    base;
   logic [PW-1:0]    hi_m1;
   logic [PW-1:0]    lim_rem;
   logic [BW:0]      lim_off;
   logic [W-1:0]     scan_free;
   logic [2*W-1:0]   window;
   logic [BW+1:0]    small_idx;
   logic             small_found;
   logic [BW:0]      lead;
   logic [PW:0]      lead_sum;
   logic             large_found;
   logic [PW-1:0]    streak_next;
   logic             scan_found;
   logic [PW-1:0]    scan_start;
   logic             last_word;
   logic [BW:0]      lo_off, hi_off;
   logic [PW:0]      base_top;
   logic [W-1:0]     pmask;
   logic             dbl;
   logic [BW:0]      set_delta, clr_delta;
   logic             start_fail;

   // ---------------- datapath evaluation ----------------
   always_comb begin
      rd_word  = rd_valid_ff ? rd_data_ff : '1;
      base     = {word_ff, BW'(0)};
      hi_m1    = hi_ff - 1'b1;
      last_word = (word_ff == hi_m1[AW+BW-1:BW]);

      lim_rem   = limit - base;
      lim_off   = (lim_rem >= PW'(W)) ? (BW + 1)'(W) : lim_rem[BW:0];
      scan_free = ~rd_word & below_mask(lim_off);

      // short runs: a run ending in this word started in this or the last word
      window = {scan_free, prevf_ff};
      for (int k = 0; k < BW - 1; k++) begin
         if (4'(k) < cmd_ff.order) window = window & (window >> (1 << k));
      end
      small_found = |window;
      small_idx   = '0;
      for (int i = 2 * W - 1; i >= 0; i--) begin
         if (window[i]) small_idx = (BW + 2)'(i);
      end

      // long runs: carry the free streak across whole words
      lead        = low_ones(scan_free);
      lead_sum    = (PW + 1)'(streak_ff) + (PW + 1)'(lead);
      large_found = bpa_pkg::RUN_W'(lead_sum) >= cmd_ff.run;
      streak_next = (&scan_free) ? streak_ff + PW'(W) : PW'(high_ones(scan_free));

      if (cmd_ff.order < 4'(BW)) begin
         scan_found = small_found;
         scan_start = base + PW'(small_idx) - PW'(W);
      end else begin
         scan_found = large_found;
         scan_start = base - streak_ff;
      end

      base_top = (PW + 1)'(base) + (PW + 1)'(W);
      lo_off   = (lo_ff <= base) ? '0 : (BW + 1)'(lo_ff - base);
      hi_off   = ((PW + 1)'(hi_ff) >= base_top) ? (BW + 1)'(W) : (BW + 1)'(hi_ff - base);
      pmask    = below_mask(hi_off) & ~below_mask(lo_off);
      dbl       = |(~rd_word & pmask);
      set_delta = pop_count(~rd_word & pmask);
      clr_delta = pop_count(rd_word & pmask);
      mem_wdata = (mode_ff == bpa_pkg::PASS_SET) ? (rd_word | pmask) : (rd_word & ~pmask);

      start_fail = cmd_ff.invalid
                || ((cmd_ff.kind == bpa_pkg::REQ_ALLOC)
                    && (((bpa_pkg::RUN_W)'(fc_ff) < cmd_ff.run) || (hi_ff == '0)))
                || ((cmd_ff.kind != bpa_pkg::REQ_ALLOC) && (hi_ff <= lo_ff));
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpa_pkg::BK_IDLE: begin
            if (!cmd_empty) state_in = bpa_pkg::BK_START;
         end
         bpa_pkg::BK_START: begin
            if (start_fail) begin
               state_in = bpa_pkg::BK_DONE;
            end else if (cmd_ff.kind == bpa_pkg::REQ_ALLOC) begin
               state_in = bpa_pkg::BK_SCAN_RD;
            end else begin
               state_in = bpa_pkg::BK_PASS_RD;
            end
         end
         bpa_pkg::BK_SCAN_RD: state_in = bpa_pkg::BK_SCAN_EV;
         bpa_pkg::BK_SCAN_EV: begin
            if (scan_found) begin
               state_in = bpa_pkg::BK_PASS_RD;
            end else if (last_word) begin
               state_in = bpa_pkg::BK_DONE;
            end else begin
               state_in = bpa_pkg::BK_SCAN_RD;
            end
         end
         bpa_pkg::BK_PASS_RD: state_in = bpa_pkg::BK_PASS_EV;
         bpa_pkg::BK_PASS_EV: begin
            if (mode_ff == bpa_pkg::PASS_CHECK) begin
               state_in = dbl ? bpa_pkg::BK_DONE : bpa_pkg::BK_PASS_RD;
            end else begin
               state_in = last_word ? bpa_pkg::BK_DONE : bpa_pkg::BK_PASS_RD;
            end
         end
         bpa_pkg::BK_DONE: begin
            if (!rsp_full) state_in = bpa_pkg::BK_IDLE;
         end
         default: state_in = bpa_pkg::BK_IDLE;
      endcase
   end

   // ---------------- outputs ----------------
   always_comb begin
      cmd_pop  = (state_ff == bpa_pkg::BK_IDLE) && !cmd_empty;
      mem_rd   = (state_ff == bpa_pkg::BK_SCAN_RD) || (state_ff == bpa_pkg::BK_PASS_RD);
      mem_we   = (state_ff == bpa_pkg::BK_PASS_EV) && (mode_ff != bpa_pkg::PASS_CHECK);
      rsp_push = (state_ff == bpa_pkg::BK_DONE) && !rsp_full;
      rsp_item.status     = status_ff;
      rsp_item.alloc_page = grant_ff;
      rsp_item.free_total = fc_ff;
   end

   // ---------------- working registers ----------------
   always_comb begin
      cmd_in    = cmd_ff;
      mode_in   = mode_ff;
      status_in = status_ff;
      word_in   = word_ff;
      streak_in = streak_ff;
      prevf_in  = prevf_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      grant_in  = grant_ff;
      fc_in     = fc_ff;
      unique case (state_ff)
         bpa_pkg::BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_in = cmd_data;
               lo_in  = cmd_data.lo;
               hi_in  = cmd_data.hi;
            end
         end
         bpa_pkg::BK_START: begin
            status_in = bpa_pkg::ST_OK;
            grant_in  = '0;
            streak_in = '0;
            prevf_in  = '0;
            word_in   = lo_ff[AW+BW-1:BW];
            unique case (cmd_ff.kind)
               bpa_pkg::REQ_FREE:    mode_in = bpa_pkg::PASS_CHECK;
               bpa_pkg::REQ_RELEASE: mode_in = bpa_pkg::PASS_CLEAR;
               default:              mode_in = bpa_pkg::PASS_SET;
            endcase
            if (cmd_ff.invalid) begin
               status_in = bpa_pkg::ST_INVALID;
            end else if (cmd_ff.kind == bpa_pkg::REQ_ALLOC) begin
               word_in = '0;
               if ((bpa_pkg::RUN_W)'(fc_ff) < cmd_ff.run) begin
                  status_in = bpa_pkg::ST_OOM;
               end else if (hi_ff == '0) begin
                  status_in = bpa_pkg::ST_NO_RUN;
               end
            end
         end
         bpa_pkg::BK_SCAN_EV: begin
            prevf_in  = scan_free;
            streak_in = streak_next;
            word_in   = word_ff + 1'b1;
            if (scan_found) begin
               // mark the granted run
               lo_in    = scan_start;
               hi_in    = scan_start + PW'(cmd_ff.run);
               word_in  = scan_start[AW+BW-1:BW];
               grant_in = scan_start[11:0];
               mode_in  = bpa_pkg::PASS_SET;
            end else if (last_word) begin
               status_in = bpa_pkg::ST_NO_RUN;
            end
         end
         bpa_pkg::BK_PASS_EV: begin
            word_in = word_ff + 1'b1;
            unique case (mode_ff)
               bpa_pkg::PASS_CHECK: begin
                  if (dbl) begin
                     status_in = bpa_pkg::ST_DOUBLE;
                  end else if (last_word) begin
                     mode_in = bpa_pkg::PASS_CLEAR;
                     word_in = lo_ff[AW+BW-1:BW];
                  end
               end
               bpa_pkg::PASS_SET:   fc_in = fc_ff - PW'(set_delta);
               default:             fc_in = fc_ff + PW'(clr_delta);
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::BK_IDLE;
         fc_ff    <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         fc_ff    <= fc_in;
         if (mem_we) valid_ff[word_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      mode_ff   <= mode_in;
      status_ff <= status_in;
      word_ff   <= word_in;
      streak_ff <= streak_in;
      prevf_ff  <= prevf_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      grant_ff  <= grant_in;
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         rd_data_ff  <= mem_ff[word_ff];
         rd_valid_ff <= valid_ff[word_ff];
      end
      if (mem_we) begin
         mem_ff[word_ff] <= mem_wdata;
      end
   end

endmodule

### tb/bitmap_page_allocator_checker.sv
// Checker for the bitmap page allocator: keeps its own copy of the bitmap, the free count
// and the managed size, predicts each request's result and compares it. Depends on bpa_pkg.
`timescale 1ns / 1ps

module bitmap_page_allocator_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic                       full,
   input  bpa_pkg::req_item_type      req_data,
   input  logic                       empty,
   input  logic                       pop,
   input  bpa_pkg::rsp_item_type      rsp_data,
   input  logic                       csr_we,
   input  logic [bpa_pkg::PAGE_W-1:0] csr_wdata,
   output int                         mismatch_count,
   output int                         pending_count,
   output int                         request_count
);

   bit                    page_taken [0:bpa_pkg::NUM_PAGES-1];
   int unsigned           pages_free;
   int unsigned           managed_size;
   bpa_pkg::rsp_item_type awaited_results[$];

   function automatic int unsigned page_limit();
      return (managed_size > bpa_pkg::NUM_PAGES) ? bpa_pkg::NUM_PAGES : managed_size;
   endfunction

   function automatic bit is_taken(int unsigned p);
      if (p >= page_limit()) return 1'b1;
      return page_taken[p];
   endfunction

   function automatic void mark_taken(int unsigned p);
      if (!is_taken(p)) begin
         page_taken[p] = 1'b1;
         pages_free--;
      end
   endfunction

   function automatic void mark_free(int unsigned p);
      if (p < page_limit() && is_taken(p)) begin
         page_taken[p] = 1'b0;
         pages_free++;
      end
   endfunction

   function automatic bpa_pkg::rsp_item_type apply_request(bpa_pkg::req_item_type r);
      bpa_pkg::rsp_item_type res;
      int unsigned  run_len;
      int unsigned  lim;
      int unsigned  streak;
      int unsigned  first;
      bit           found;
      res = '0;
      res.status = bpa_pkg::ST_OK;
      run_len = 32'd1 << r.order;
      lim = page_limit();
      case (bpa_pkg::req_kind_type'(r.req_type))
         bpa_pkg::REQ_ALLOC: begin
            if (pages_free < run_len) begin
               res.status = bpa_pkg::ST_OOM;
            end else begin
               streak = 0;
               first = 0;
               found = 1'b0;
               for (int unsigned p = 0; p < lim && !found; p++) begin
                  if (!is_taken(p)) begin
                     if (streak == 0) first = p;
                     streak++;
                     if (streak == run_len) found = 1'b1;
                  end else begin
                     streak = 0;
                  end
               end
               if (!found) begin
                  res.status = bpa_pkg::ST_NO_RUN;
               end else begin
                  for (int unsigned i = 0; i < run_len; i++) mark_taken(first + i);
                  res.alloc_page = first[11:0];
               end
            end
         end
         bpa_pkg::REQ_FREE: begin
            if (r.start_page >= lim) begin
               res.status = bpa_pkg::ST_INVALID;
            end else begin
               // pages above the managed size read as used, so never a double free
               for (int unsigned i = 0; i < run_len; i++)
                  if (!is_taken(r.start_page + i)) res.status = bpa_pkg::ST_DOUBLE;
               if (res.status == bpa_pkg::ST_OK)
                  for (int unsigned i = 0; i < run_len; i++) mark_free(r.start_page + i);
            end
         end
         bpa_pkg::REQ_RESERVE: begin
            for (int unsigned i = 0; i < r.page_count; i++) mark_taken(r.start_page + i);
         end
         default: begin
            for (int unsigned i = 0; i < r.page_count; i++) mark_free(r.start_page + i);
         end
      endcase
      res.free_total = pages_free[12:0];
      return res;
   endfunction

   assign pending_count = awaited_results.size();

   always @(posedge clock) begin
      bpa_pkg::rsp_item_type want;
      if (reset) begin
         for (int p = 0; p < bpa_pkg::NUM_PAGES; p++) page_taken[p] = 1'b1;
         pages_free = 0;
         managed_size = bpa_pkg::NUM_PAGES;
         awaited_results.delete();
         mismatch_count <= 0;
         request_count <= 0;
      end else begin
         if (csr_we) managed_size = csr_wdata;
         if (pop && !empty) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = awaited_results.pop_front();
               if (want.status !== rsp_data.status || want.alloc_page !== rsp_data.alloc_page
                   || want.free_total !== rsp_data.free_total) begin
                  $display("%0t: result mismatch expected %p actual %p", $time, want, rsp_data);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (push && !full) begin
            awaited_results.push_back(apply_request(req_data));
            request_count <= request_count + 1;
         end
      end
   end

endmodule

### tb/bitmap_page_allocator_tb.sv
// Testbench top for the bitmap page allocator: clock, reset, request stimulus,
// managed-size writes and the verdict. Depends on bpa_pkg and the checker module.
`timescale 1ns / 1ps

module bitmap_page_allocator_tb;

   logic                        clock;
   logic                        reset;
   logic                        push;
   logic                        full;
   bpa_pkg::req_item_type       req_data;
   logic                        empty;
   logic                        pop;
   bpa_pkg::rsp_item_type       rsp_data;
   logic                        csr_we;
   logic [bpa_pkg::PAGE_W-1:0]  csr_wdata;
   int                          mismatch_count;
   int                          pending_count;
   int                          request_count;

   // idling percentages of the current phase
   int                  push_idle_pct;
   int                  pop_stall_pct;
   int unsigned         current_limit;

   bitmap_page_allocator dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   bitmap_page_allocator_checker checker_i (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .pending_count(pending_count),
      .request_count(request_count)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // receiver: stall at random with the phase's percentage
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // hold the request until it is taken; insert random idle cycles ahead of it
   task automatic send_request(bpa_pkg::req_kind_type kind, int unsigned ord,
                               int unsigned start, int unsigned cnt);
      bpa_pkg::req_item_type r;
      r.req_type = kind;
      r.order = ord[3:0];
      r.start_page = start[11:0];
      r.page_count = cnt[12:0];
      while ($urandom_range(99) < push_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
   endtask

   // drain every result, let the sequencer settle, then write the managed size
   task automatic set_managed_size(int unsigned size);
      push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= size[12:0];
      @(posedge clock);
      csr_we <= 1'b0;
      current_limit = (size > bpa_pkg::NUM_PAGES) ? bpa_pkg::NUM_PAGES : size;
   endtask

   task automatic send_random_request();
      int unsigned pick;
      int unsigned lim;
      lim = (current_limit == 0) ? 1 : current_limit;
      pick = $urandom_range(99);
      if (pick < 35) begin
         // mostly small orders so that grants keep succeeding
         send_request(bpa_pkg::REQ_ALLOC, ($urandom_range(9) == 0) ? $urandom_range(15)
                      : $urandom_range(4), 0, $urandom_range(8191));
      end else if (pick < 60) begin
         send_request(bpa_pkg::REQ_FREE, $urandom_range(4),
                      ($urandom_range(7) == 0) ? $urandom_range(4095)
                      : $urandom_range(lim - 1), $urandom_range(8191));
      end else if (pick < 80) begin
         send_request(bpa_pkg::REQ_RELEASE, $urandom_range(15),
                      ($urandom_range(7) == 0) ? $urandom_range(4095)
                      : $urandom_range(lim - 1),
                      ($urandom_range(19) == 0) ? $urandom_range(8191) : $urandom_range(96));
      end else begin
         send_request(bpa_pkg::REQ_RESERVE, $urandom_range(15),
                      ($urandom_range(7) == 0) ? $urandom_range(4095)
                      : $urandom_range(lim - 1),
                      ($urandom_range(19) == 0) ? $urandom_range(8191) : $urandom_range(48));
      end
   endtask

   initial begin
      int unsigned phase_size [6];
      int          phase_idle [6];
      int          phase_stall [6];
      phase_size = '{4096, 256, 1, 8191, 64, 4096};
      phase_idle = '{0, 55, 0, 9, 55, 0};
      phase_stall = '{0, 0, 55, 9, 55, 0};
      reset <= 1'b1;
      push <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      push_idle_pct = 0;
      pop_stall_pct = 0;
      current_limit = bpa_pkg::NUM_PAGES;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: everything used after reset, so a grant runs out of memory
      send_request(bpa_pkg::REQ_ALLOC, 0, 0, 0);
      send_request(bpa_pkg::REQ_FREE, 0, 0, 0);
      send_request(bpa_pkg::REQ_RELEASE, 0, 0, 4096);
      send_request(bpa_pkg::REQ_ALLOC, 0, 0, 0);
      send_request(bpa_pkg::REQ_ALLOC, 12, 0, 0);
      send_request(bpa_pkg::REQ_ALLOC, 13, 0, 0);
      send_request(bpa_pkg::REQ_ALLOC, 15, 0, 0);
      send_request(bpa_pkg::REQ_FREE, 12, 0, 0);
      send_request(bpa_pkg::REQ_FREE, 0, 0, 0);
      send_request(bpa_pkg::REQ_RESERVE, 0, 4095, 0);
      send_request(bpa_pkg::REQ_RESERVE, 0, 1, 1);
      send_request(bpa_pkg::REQ_RESERVE, 0, 3, 1);
      send_request(bpa_pkg::REQ_ALLOC, 11, 0, 0);
      send_request(bpa_pkg::REQ_ALLOC, 10, 0, 0);
      send_request(bpa_pkg::REQ_FREE, 3, 4092, 0);
      send_request(bpa_pkg::REQ_RESERVE, 0, 4000, 8191);
      send_request(bpa_pkg::REQ_FREE, 2, 4094, 0);
      send_request(bpa_pkg::REQ_RELEASE, 15, 4000, 8191);
      set_managed_size(100);
      // free past the end, free straddling the top, shrunk-size grants
      send_request(bpa_pkg::REQ_FREE, 0, 4095, 0);
      send_request(bpa_pkg::REQ_FREE, 0, 100, 0);
      send_request(bpa_pkg::REQ_FREE, 3, 96, 0);
      send_request(bpa_pkg::REQ_RELEASE, 0, 90, 50);
      send_request(bpa_pkg::REQ_ALLOC, 6, 0, 0);
      send_request(bpa_pkg::REQ_ALLOC, 4, 0, 0);
      send_request(bpa_pkg::REQ_RESERVE, 0, 0, 8191);

      for (int ph = 0; ph < 6; ph++) begin
         set_managed_size(phase_size[ph]);
         push_idle_pct = phase_idle[ph];
         pop_stall_pct = phase_stall[ph];
         for (int n = 0; n < 320; n++) send_random_request();
      end

      push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("covered %0d requests of all four kinds over several managed sizes,",
               request_count);
      $display("with idle and stall phases on both sides");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40_000_000;
      $display("timeout with %0d results outstanding", pending_count);
      $display("status: fail");
      $finish;
   end

endmodule

### sim.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_queue.sv
hw/rtl/bpa_front.sv
hw/rtl/bpa_back.sv
hw/rtl/bitmap_page_allocator.sv
tb/bitmap_page_allocator_checker.sv
tb/bitmap_page_allocator_tb.sv
